// ===== src/smbe_pkg.sv =====
// ---------------------------------------------------------------------------
// smbe_pkg: shared types and constants for the sparse mask bit encoder
// Widths, chunk codes, sequencer state encodings and the 8-bit popcount.
// ---------------------------------------------------------------------------
`default_nettype none

package smbe_pkg;

    localparam int MASK_W   = 64;               // input mask width
    localparam int POS_W    = $clog2(MASK_W);   // bit position width
    localparam int CNT_W    = POS_W + 1;        // holds 0..MASK_W
    localparam int CWIDTH_W = 7;                // chunk_width port width
    localparam int SLICE_W  = 8;                // bits counted per cycle
    localparam int SLICE_N  = MASK_W / SLICE_W;
    localparam int SIDX_W   = $clog2(SLICE_N);
    localparam int SCNT_W   = $clog2(SLICE_W) + 1;
    localparam int LIST_MAX = 7;                // largest count the 3-bit field holds
    localparam int REM_W    = 3;

    // chunk values
    localparam logic [1:0] TAG_FULL = 2'h3;
    localparam logic [1:0] TAG_LIST = 2'h1;
    localparam logic       TAG_RAW  = 1'b0;

    // chunk widths
    localparam logic [CWIDTH_W-1:0] WID_TAG2 = CWIDTH_W'(2);
    localparam logic [CWIDTH_W-1:0] WID_TAG1 = CWIDTH_W'(1);
    localparam logic [CWIDTH_W-1:0] WID_POL  = CWIDTH_W'(1);
    localparam logic [CWIDTH_W-1:0] WID_CNT  = CWIDTH_W'(3);
    localparam logic [CWIDTH_W-1:0] WID_POS  = CWIDTH_W'(POS_W);
    localparam logic [CWIDTH_W-1:0] WID_RAW  = CWIDTH_W'(MASK_W);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_COUNT = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    typedef enum logic [3:0] {
        PH_TAG = 4'b0001,
        PH_POL = 4'b0010,
        PH_CNT = 4'b0100,
        PH_POS = 4'b1000
    } phase_t;

    function automatic logic [SCNT_W-1:0] pop_slice(input logic [SLICE_W-1:0] v);
        logic [SCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < SLICE_W; i++) begin
            n = n + SCNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/smbe_bit_scan.sv =====
// ---------------------------------------------------------------------------
// smbe_bit_scan: lowest set bit finder
// Gives the position of the lowest set bit of a word and the word with
// that bit cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module smbe_bit_scan (
    input  wire logic [smbe_pkg::MASK_W-1:0] vec,
    output logic      [smbe_pkg::POS_W-1:0]  pos,
    output logic      [smbe_pkg::MASK_W-1:0] rest
);
    import smbe_pkg::*;

    // scan from the top so the lowest set bit wins
    always_comb
    begin
        pos = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

    // drop the lowest set bit
    assign rest = vec & (vec - MASK_W'(1));

endmodule

`default_nettype wire

// ===== src/sparse_mask_bit_encoder.sv =====
// ---------------------------------------------------------------------------
// sparse_mask_bit_encoder: variable-length code for a 64-bit mask
// Splits the code of one mask into bit-field chunks (value, width, last).
// ---------------------------------------------------------------------------
// Sequence: the mask transfer loads the mask, the serial popcount runs over
//   8-bit slices, and then the chunks go out through the output register.
// Input: no new mask is taken until the last of the 1 to 10 chunks of the
//   previous one is in the output register; chunks go one per cycle unless stalled.
// Reset: asynchronous, active low; the sequencer returns to idle and the
//   output register is emptied. Payload registers are not reset.
`default_nettype none

module sparse_mask_bit_encoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [smbe_pkg::MASK_W-1:0]     mask,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [smbe_pkg::MASK_W-1:0]     chunk_value,
    output logic      [smbe_pkg::CWIDTH_W-1:0]   chunk_width,
    output logic                                 last_chunk
);
    import smbe_pkg::*;

    // sequencer
    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [SIDX_W-1:0]     sidx_reg, sidx_next;

    // working data
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [MASK_W-1:0]     enc_reg, enc_next;
    logic [REM_W-1:0]      rem_reg, rem_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]     value_reg, value_next;
    logic [CWIDTH_W-1:0]   width_reg, width_next;
    logic                  last_reg, last_next;

    // handshake, popcount slice, scan results and values derived from the finished count
    logic                  in_xfer;
    logic                  out_free;
    logic                  is_full;
    logic                  inverted;
    logic [CNT_W-1:0]      zero_count;
    logic [CNT_W-1:0]      list_count;
    logic                  is_list;
    logic [SLICE_W-1:0]    slice;
    logic [POS_W-1:0]      scan_pos;
    logic [MASK_W-1:0]     scan_rest;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    // the output register can take a chunk when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign chunk_value = value_reg;
    assign chunk_width = width_reg;
    assign last_chunk  = last_reg;

    // current 8-bit slice for the serial popcount
    assign slice = mask_reg[{sidx_reg, {($clog2(SLICE_W)){1'b0}}} +: SLICE_W];

    assign zero_count = CNT_W'(MASK_W) - count_reg;
    assign is_full    = (count_reg == CNT_W'(MASK_W));
    assign inverted   = (zero_count < count_reg);
    assign list_count = inverted ? zero_count : count_reg;
    assign is_list    = !is_full && (list_count <= CNT_W'(LIST_MAX));

    // shared lowest-set-bit finder walks the position list
    smbe_bit_scan u_scan (
        .vec  (enc_reg),
        .pos  (scan_pos),
        .rest (scan_rest)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sidx_next      = sidx_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        enc_next       = enc_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        width_next     = width_reg;
        last_next      = last_reg;

        // drop the output once the transfer happens
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mask_next  = mask;
                    count_next = '0;
                    sidx_next  = '0;
                    state_next = ST_COUNT;
                end
            end

            ST_COUNT:
            begin
                // accumulate one slice per cycle
                count_next = count_reg + CNT_W'(pop_slice(slice));
                sidx_next  = sidx_reg + SIDX_W'(1);
                if (sidx_reg == SIDX_W'(SLICE_N - 1))
                begin
                    state_next = ST_EMIT;
                    phase_next = PH_TAG;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    case (phase_reg)
                        PH_TAG:
                        begin
                            if (is_full)
                            begin
                                value_next = MASK_W'(TAG_FULL);
                                width_next = WID_TAG2;
                                last_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else if (is_list)
                            begin
                                value_next = MASK_W'(TAG_LIST);
                                width_next = WID_TAG2;
                                last_next  = 1'b0;
                                enc_next   = inverted ? ~mask_reg : mask_reg;
                                rem_next   = REM_W'(list_count);
                                phase_next = PH_POL;
                            end
                            else
                            begin
                                value_next = MASK_W'(TAG_RAW);
                                width_next = WID_TAG1;
                                last_next  = 1'b0;
                                phase_next = PH_POL;
                            end
                        end

                        PH_POL:
                        begin
                            if (is_list)
                            begin
                                value_next = MASK_W'(inverted);
                                width_next = WID_POL;
                                last_next  = 1'b0;
                                phase_next = PH_CNT;
                            end
                            else
                            begin
                                // raw form: the mask itself closes the code
                                value_next = mask_reg;
                                width_next = WID_RAW;
                                last_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end

                        PH_CNT:
                        begin
                            value_next = MASK_W'(rem_reg);
                            width_next = WID_CNT;
                            last_next  = (rem_reg == '0);
                            if (rem_reg == '0)
                            begin
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_POS;
                            end
                        end

                        PH_POS:
                        begin
                            value_next = MASK_W'(scan_pos);
                            width_next = WID_POS;
                            last_next  = (rem_reg == REM_W'(1));
                            enc_next   = scan_rest;
                            rem_next   = rem_reg - REM_W'(1);
                            if (rem_reg == REM_W'(1))
                            begin
                                state_next = ST_IDLE;
                            end
                        end

                        default:
                        begin
                            out_valid_next = out_valid_reg && out_stall;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_TAG;
            sidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        count_reg <= count_next;
        enc_reg   <= enc_next;
        rem_reg   <= rem_next;
        value_reg <= value_next;
        width_reg <= width_next;
        last_reg  <= last_next;
    end

    // an accepted mask always starts the popcount
    a_xfer_starts_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_COUNT) && (sidx_reg == '0))
        else $error("mask transfer did not start the popcount");

    // the popcount never exceeds the mask width
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg <= CNT_W'(MASK_W)))
        else $error("popcount out of range");

    // listing positions needs a bit left to find and a nonzero remainder
    a_pos_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && phase_reg == PH_POS)
            |-> (rem_reg != '0) && (enc_reg != '0))
        else $error("position list ran dry");

    // a last chunk sends the sequencer back to idle
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && last_next) |=> (state_reg == ST_IDLE))
        else $error("last chunk did not end the item");

endmodule

`default_nettype wire
